// ===== design/ms_delay_event_cycle_timer_unit_macros.svh =====
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef MS_DELAY_EVENT_CYCLE_TIMER_UNIT_MACROS_SVH
`define MS_DELAY_EVENT_CYCLE_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define MDCT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mdct assertion failed");

// next-cycle implication
`define MDCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mdct assertion failed");

`endif

// ===== design/mdct_pkg.sv =====
`timescale 1ns / 1ps
package mdct_pkg;

	localparam int CNT_BITS   = 24;
	localparam int WRAP_W     = 8;
	localparam int CPM_W      = 23;
	localparam int MS_W       = 16;
	localparam int PROD_W     = 32;
	localparam int CYC_W      = 32;
	localparam int CMD_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 23;

	localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
	localparam logic [CPM_W-1:0] CPM_RESET = CPM_W'(8000);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK         = 3'd0,
		CMD_START_DELAY  = 3'd1,
		CMD_START_EVENT  = 3'd2,
		CMD_CHECK_EVENT  = 3'd3,
		CMD_START_CYCLES = 3'd4,
		CMD_READ_CYCLES  = 3'd5,
		CMD_STOP_CYCLES  = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IDLE        = 3'd0,
		MODE_DELAY_WRAPS = 3'd1,
		MODE_DELAY_REST  = 3'd2,
		MODE_EVENT       = 3'd3,
		MODE_CYCLES      = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOCKS_PER_MS  = 1'b0,
		REG_USE_CORE_CLOCK = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t              command;
		logic [PROD_W-1:0] product;
		logic              ref_edge;
		logic              use_core;
	} item_t;

	typedef struct packed {
		logic [CYC_W-1:0] cycle_count;
		logic             event_seen;
		logic             delay_done;
		logic             running;
	} result_t;

	function automatic logic [CYC_W-1:0] cycles_now(
		input logic [WRAP_W-1:0]   wraps,
		input logic [CNT_BITS-1:0] cnt
	);
		logic [63:0] hi;
		logic [63:0] lo;
		hi = 64'(wraps) << CNT_BITS;
		lo = (64'(1) << CNT_BITS) - 64'(cnt);
		return CYC_W'(hi | lo);
	endfunction

endpackage

// ===== design/mdct_cmd_if.sv =====
`timescale 1ns / 1ps
interface mdct_cmd_if;
	import mdct_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [MS_W-1:0]   delay_ms;
	logic              ref_edge;

	modport source (output valid, command, delay_ms, ref_edge, input ready);
	modport sink (input valid, command, delay_ms, ref_edge, output ready);
endinterface

// ===== design/mdct_res_if.sv =====
`timescale 1ns / 1ps
interface mdct_res_if;
	import mdct_pkg::*;

	logic             valid;
	logic             ready;
	logic [CYC_W-1:0] cycle_count;
	logic             event_seen;
	logic             delay_done;
	logic             running;

	modport source (output valid, cycle_count, event_seen, delay_done, running, input ready);
	modport sink (input valid, cycle_count, event_seen, delay_done, running, output ready);
endinterface

// ===== design/mdct_in_stage.sv =====
`timescale 1ns / 1ps
module mdct_in_stage
	import mdct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	mdct_cmd_if.sink              cmd_ch,
	input  logic                  adv,
	output logic                  valid_s1,
	output item_t                 item_s1
);

	logic [CPM_W-1:0]      cpm_q;
	logic                  use_core_q;
	logic [CPM_W+MS_W-1:0] prod_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q      <= CPM_RESET;
			use_core_q <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CLOCKS_PER_MS:  cpm_q <= wr_data[CPM_W-1:0];
				REG_USE_CORE_CLOCK: use_core_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// delay cycles, only the low word is kept
	assign prod_full = (CPM_W+MS_W)'(cpm_q) * (CPM_W+MS_W)'(cmd_ch.delay_ms);

	assign cmd_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			item_s1.command  <= cmd_t'(cmd_ch.command);
			item_s1.product  <= PROD_W'(prod_full);
			item_s1.ref_edge <= cmd_ch.ref_edge;
			item_s1.use_core <= use_core_q;
		end
	end

endmodule

// ===== design/mdct_core.sv =====
`timescale 1ns / 1ps
`include "ms_delay_event_cycle_timer_unit_macros.svh"
module mdct_core
	import mdct_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item_s1,
	output result_t res
);

	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic [CNT_BITS-1:0] rel_q, rel_d;
	logic [WRAP_W-1:0]   wrap_q, wrap_d;
	mode_t               mode_q, mode_d;
	logic [WRAP_W-1:0]   pw_q, pw_d;
	logic [CNT_BITS-1:0] pr_q, pr_d;
	logic                sel_q, sel_d;

	logic [CNT_BITS-1:0] cnt_dec;
	logic [WRAP_W-1:0]   wrap_inc;
	logic [WRAP_W-1:0]   prod_wraps;
	logic [CNT_BITS-1:0] prod_rem;

	assign cnt_dec    = cnt_q - CNT_BITS'(1);
	assign wrap_inc   = wrap_q + WRAP_W'(1);
	assign prod_wraps = WRAP_W'(item_s1.product >> CNT_BITS);
	assign prod_rem   = item_s1.product[CNT_BITS-1:0];

	always_comb begin
		cnt_d  = cnt_q;
		rel_d  = rel_q;
		wrap_d = wrap_q;
		mode_d = mode_q;
		pw_d   = pw_q;
		pr_d   = pr_q;
		sel_d  = sel_q;
		res    = '0;
		case (item_s1.command)
			CMD_TICK: begin
				if (mode_q != MODE_IDLE && (sel_q || item_s1.ref_edge)) begin
					if (cnt_q == '0) begin
						cnt_d = rel_q;
					end else begin
						cnt_d = cnt_dec;
						if (cnt_dec == '0) begin
							wrap_d = wrap_inc;
							if (mode_q == MODE_DELAY_WRAPS && wrap_inc >= pw_q) begin
								if (pr_q == '0) begin
									mode_d         = MODE_IDLE;
									res.delay_done = 1'b1;
								end else begin
									wrap_d = '0;
									rel_d  = pr_q;
									cnt_d  = '0;
									mode_d = MODE_DELAY_REST;
								end
							end else if (mode_q == MODE_DELAY_REST) begin
								mode_d         = MODE_IDLE;
								res.delay_done = 1'b1;
							end
						end
					end
				end
			end
			CMD_START_DELAY: begin
				pw_d  = prod_wraps;
				pr_d  = prod_rem;
				sel_d = item_s1.use_core;
				if (prod_wraps != '0) begin
					wrap_d = '0;
					rel_d  = CNT_MAX;
					cnt_d  = '0;
					mode_d = MODE_DELAY_WRAPS;
				end else if (prod_rem == '0) begin
					// nothing to wait for
					mode_d         = MODE_IDLE;
					res.delay_done = 1'b1;
				end else begin
					wrap_d = '0;
					rel_d  = prod_rem;
					cnt_d  = '0;
					mode_d = MODE_DELAY_REST;
				end
			end
			CMD_START_EVENT: begin
				wrap_d = '0;
				rel_d  = prod_rem;
				cnt_d  = '0;
				sel_d  = item_s1.use_core;
				mode_d = MODE_EVENT;
			end
			CMD_CHECK_EVENT: begin
				if (wrap_q != '0) begin
					mode_d         = MODE_IDLE;
					res.event_seen = 1'b1;
				end
			end
			CMD_START_CYCLES: begin
				wrap_d = '0;
				rel_d  = CNT_MAX;
				cnt_d  = '0;
				sel_d  = 1'b1;
				mode_d = MODE_CYCLES;
			end
			CMD_READ_CYCLES: begin
				res.cycle_count = cycles_now(wrap_q, cnt_q);
			end
			CMD_STOP_CYCLES: begin
				mode_d          = MODE_IDLE;
				res.cycle_count = cycles_now(wrap_q, cnt_q);
			end
			default: ;
		endcase
		res.running = (mode_d != MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rel_q  <= '0;
			wrap_q <= '0;
			mode_q <= MODE_IDLE;
			pw_q   <= '0;
			pr_q   <= '0;
			sel_q  <= 1'b1;
		end else if (adv) begin
			cnt_q  <= cnt_d;
			rel_q  <= rel_d;
			wrap_q <= wrap_d;
			mode_q <= mode_d;
			pw_q   <= pw_d;
			pr_q   <= pr_d;
			sel_q  <= sel_d;
		end
	end

	`MDCT_ASSERT_IMPL(a_done_only_in_delay, adv && res.delay_done, item_s1.command == CMD_START_DELAY || mode_q == MODE_DELAY_WRAPS || mode_q == MODE_DELAY_REST)
	`MDCT_ASSERT_IMPL(a_seen_stops, adv && res.event_seen, !res.running && wrap_q != '0)
	`MDCT_ASSERT_IMPL(a_count_only_on_read, adv && res.cycle_count != '0, item_s1.command == CMD_READ_CYCLES || item_s1.command == CMD_STOP_CYCLES)
	`MDCT_ASSERT_NEXT(a_hold_when_stalled, !adv, $stable(cnt_q) && $stable(wrap_q) && $stable(mode_q))
	`MDCT_ASSERT_NEXT(a_idle_tick_holds, adv && mode_q == MODE_IDLE && item_s1.command == CMD_TICK, $stable(cnt_q) && $stable(wrap_q))

endmodule

// ===== design/ms_delay_event_cycle_timer_unit.sv =====
`timescale 1ns / 1ps
// millisecond delay, one-shot event and cycle-count timer on a 24-bit reloading
// down counter with an 8-bit wrap counter
// cmd_ch carries one command word per item: a tick (one counter clock, with an
// optional reference edge) or a start, check, read or stop command
// res_ch returns exactly one result word for every command word, in order
// configuration goes through wr_en / wr_index / wr_data: index 0 is clocks per
// millisecond, index 1 selects counting on every tick or on reference edges only
// a command passes the input register (with the delay product) and then the
// result register, from which res_ch presents it
// throughput: one command per cycle while res_ch does not stall; the counter
// state is updated straight from the input register, so back-to-back ticks
// are taken at full rate
// when res_ch stalls the result register holds, the input register fills, and
// cmd_ch.ready drops until the result is taken; no word is dropped
// reset: counter, wrap count and reload clear, the timer is stopped, clocks per
// millisecond is 8000 and every tick counts
module ms_delay_event_cycle_timer_unit
	import mdct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	mdct_cmd_if.sink              cmd_ch,
	mdct_res_if.source            res_ch
);

	logic    valid_s1;
	item_t   item_s1;
	logic    adv;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	assign adv = valid_s1 && (!out_valid_q || res_ch.ready);

	mdct_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd_ch   (cmd_ch),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mdct_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.cycle_count = out_q.cycle_count;
	assign res_ch.event_seen  = out_q.event_seen;
	assign res_ch.delay_done  = out_q.delay_done;
	assign res_ch.running     = out_q.running;

endmodule
